>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the box suppression top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define GBS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int unsigned DEF_MAX_KEPT = 64;
    localparam logic [15:0] THR_RESET    = 16'd29491;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned SLOT_W       = 6;
    localparam int unsigned IN_TDATA_W   = 64;
    localparam int unsigned OUT_TDATA_W  = 8;
    localparam int unsigned AREA_W       = 30;
    localparam int unsigned THR_W        = 16;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_box;

    typedef struct packed {
        logic              first;
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_item;

    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_kept;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic done;     // result written to output register
        logic stored;   // surviving box written to the store
        logic at_max;   // store holds MAX_KEPT boxes
    } t_back_stat;

endpackage

`default_nettype wire

>>> hw/rtl/greedy_box_suppression_top.sv
// Boxes are processed one at a time: the engine pops a box only when idle, scans it
//   against the store, drains the pipeline and then produces the result beat.
// The scan reads one kept slot per cycle, then drains a 5-deep pipeline; a result
//   beat waits while the output register holds an unaccepted beat.
// Input beats are taken while the two-entry queue has room; config writes are always ready.
// Reset (sync, active low) clears queue, store count and output valid; threshold loads 29491.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// greedy_box_suppression_top
// Class-agnostic greedy non-maximum suppression over a box stream.
// ----------------------------------------------------------------------------
module greedy_box_suppression_top #(
    parameter int unsigned MAX_KEPT = gbs_pkg::DEF_MAX_KEPT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // box_x[15:0], box_y[31:16], box_w[46:32], box_h[61:47], zero pad [63:62]
    input  wire logic [gbs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // first_box[0]
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // keep[0], kept_slot[6:1], store_full[7]
    output logic [gbs_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    // iou_threshold[15:0]
    input  wire logic [gbs_pkg::THR_W-1:0]          i_cfg_data
);

    logic [gbs_pkg::THR_W-1:0] r_iou_threshold;
    logic                      push, pop, q_full, q_empty;
    gbs_pkg::t_item            push_item, head;
    gbs_pkg::t_back_stat       stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_threshold <= gbs_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_iou_threshold <= i_cfg_data;
        end
    end

    gbs_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (push_item)
    );

    gbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gbs_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_iou_threshold (r_iou_threshold),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_stat          (stat)
    );

    `GBS_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, push, !q_full, "push into full queue")
    `GBS_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, pop, !q_empty, "pop from empty queue")
    `GBS_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, stat.done, o_m_axis_tvalid, "result lost")
    `GBS_ASSERT_IMPLY(a_store_room, i_clk, i_rst_n, stat.stored, !stat.at_max, "store overrun")

endmodule

`default_nettype wire

>>> hw/rtl/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// Input side: unpacks a box beat, computes its area and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_front (
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // x[15:0], y[31:16], w[46:32], h[61:47], zero pad [63:62]
    input  wire logic [gbs_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // first_box[0]
    input  wire logic                              i_s_axis_tuser,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output gbs_pkg::t_item                         o_item
);

    gbs_pkg::t_box box;

    always_comb begin
        box.x = i_s_axis_tdata[15:0];
        box.y = i_s_axis_tdata[31:16];
        box.w = i_s_axis_tdata[46:32];
        box.h = i_s_axis_tdata[61:47];
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_item.first = i_s_axis_tuser;
        o_item.box   = box;
        o_item.area  = {15'b0, box.w} * {15'b0, box.h};
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbs_queue.sv
// ----------------------------------------------------------------------------
// gbs_queue
// Short FIFO that decouples box intake from the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire gbs_pkg::t_item  i_item,
    input  wire logic            i_pop,
    output gbs_pkg::t_item       o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int unsigned QW = (gbs_pkg::QUEUE_DEPTH > 1) ? $clog2(gbs_pkg::QUEUE_DEPTH) : 1;

    gbs_pkg::t_item r_mem [gbs_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QW:0]    r_cnt;

    assign o_full  = (r_cnt == (QW+1)'(gbs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(gbs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(gbs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// Scan engine: compares a box against every kept box through a pipelined
// IoU datapath, then stores a survivor if not full and emits the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_back #(
    parameter int unsigned MAX_KEPT = gbs_pkg::DEF_MAX_KEPT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [gbs_pkg::THR_W-1:0]          i_iou_threshold,
    input  wire gbs_pkg::t_item                     i_head,
    input  wire logic                               i_q_empty,
    output logic                                    o_pop,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // keep[0], kept_slot[6:1], store_full[7]
    output logic [gbs_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output gbs_pkg::t_back_stat                     o_stat
);

    localparam int unsigned CW = $clog2(MAX_KEPT + 1);
    localparam int unsigned IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int unsigned AW = gbs_pkg::AREA_W;

    gbs_pkg::t_state r_state, n_state;

    gbs_pkg::t_kept  r_mem [MAX_KEPT];
    gbs_pkg::t_kept  r_rd;

    gbs_pkg::t_box   r_cur;
    logic [AW-1:0]   r_cur_area;
    logic [CW-1:0]   r_count, r_idx;
    logic            r_supp;
    logic [4:0]      r_pv;

    logic            pop, issue, produce, at_max, keep, store;
    logic [CW+gbs_pkg::SLOT_W-1:0] slot_ext;

    // pipeline registers
    logic [14:0]     r_ow, r_oh;
    logic [AW-1:0]   r_ka1, r_ka2, r_inter, r_inter3;
    logic [AW:0]     r_uni;
    logic [AW+15:0]  r_lhs;
    logic [AW+16:0]  r_prod;
    logic            r_nz;

    logic            r_out_valid;
    logic [gbs_pkg::OUT_TDATA_W-1:0] r_out_data;

    // overlap extents, 17-bit edges so nothing wraps
    logic signed [16:0] xa, xb, ya, yb, ra, rb, ba, bb, lft, rgt, top, bot;
    logic signed [17:0] ow, oh;

    assign at_max   = (r_count == CW'(MAX_KEPT));
    assign keep     = !r_supp;
    assign store    = keep && !at_max;
    assign slot_ext = {{gbs_pkg::SLOT_W{1'b0}}, r_count};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbs_pkg::ST_IDLE:   if (!i_q_empty) n_state = gbs_pkg::ST_SCAN;
            gbs_pkg::ST_SCAN:   if (r_idx == r_count) n_state = gbs_pkg::ST_DRAIN;
            gbs_pkg::ST_DRAIN:  if (r_pv == '0) n_state = gbs_pkg::ST_RESULT;
            gbs_pkg::ST_RESULT: if (!r_out_valid || i_m_axis_tready) n_state = gbs_pkg::ST_IDLE;
            default:            n_state = gbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop     = 1'b0;
        issue   = 1'b0;
        produce = 1'b0;
        unique case (r_state)
            gbs_pkg::ST_IDLE:   pop     = !i_q_empty;
            gbs_pkg::ST_SCAN:   issue   = (r_idx != r_count);
            gbs_pkg::ST_DRAIN:  ;
            gbs_pkg::ST_RESULT: produce = !r_out_valid || i_m_axis_tready;
            default:            ;
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbs_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_supp      <= 1'b0;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= {r_pv[3:0], issue};
            if (pop) begin
                r_idx  <= '0;
                r_supp <= 1'b0;
                if (i_head.first) begin
                    r_count <= '0;
                end
            end else if (r_pv[4] && r_nz && ({1'b0, r_lhs} > r_prod)) begin
                r_supp <= 1'b1;
            end
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
                if (store) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur      <= i_head.box;
            r_cur_area <= i_head.area;
        end
        if (produce) begin
            r_out_data <= {keep && at_max,
                           store ? slot_ext[gbs_pkg::SLOT_W-1:0] : gbs_pkg::SLOT_W'(0),
                           keep};
        end
    end

    // kept store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (produce && store) begin
            r_mem[r_count[IW-1:0]] <= '{box: r_cur, area: r_cur_area};
        end
        if (issue) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_comb begin
        xa  = {r_cur.x[15], r_cur.x};
        xb  = {r_rd.box.x[15], r_rd.box.x};
        ya  = {r_cur.y[15], r_cur.y};
        yb  = {r_rd.box.y[15], r_rd.box.y};
        ra  = xa + $signed({2'b00, r_cur.w});
        rb  = xb + $signed({2'b00, r_rd.box.w});
        ba  = ya + $signed({2'b00, r_cur.h});
        bb  = yb + $signed({2'b00, r_rd.box.h});
        lft = (xa > xb) ? xa : xb;
        top = (ya > yb) ? ya : yb;
        rgt = (ra < rb) ? ra : rb;
        bot = (ba < bb) ? ba : bb;
        ow  = {rgt[16], rgt} - {lft[16], lft};
        oh  = {bot[16], bot} - {top[16], top};
    end

    // overlap never exceeds either width, so 15 bits hold it
    always_ff @(posedge i_clk) begin
        r_ow     <= (ow > 18'sd0 && oh > 18'sd0) ? ow[14:0] : 15'd0;
        r_oh     <= (ow > 18'sd0 && oh > 18'sd0) ? oh[14:0] : 15'd0;
        r_ka1    <= r_rd.area;
        r_inter  <= {15'b0, r_ow} * {15'b0, r_oh};
        r_ka2    <= r_ka1;
        r_uni    <= {1'b0, r_cur_area} + {1'b0, r_ka2} - {1'b0, r_inter};
        r_inter3 <= r_inter;
        r_prod   <= {{(AW+1){1'b0}}, i_iou_threshold} * {16'b0, r_uni};
        r_lhs    <= {r_inter3, 16'b0};
        r_nz     <= (r_uni != '0);
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        o_stat.done   = produce;
        o_stat.stored = produce && store;
        o_stat.at_max = at_max;
    end

endmodule

`default_nettype wire

>>> tb/greedy_box_suppression_top_tb.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// greedy_box_suppression_top_tb
// Streams frames of boxes through the suppression block and checks each
// verdict beat (keep, slot, store full) against an in-bench IoU predictor.
// Covers the reset threshold, threshold extremes, a full store, and random
// clustered frames under three back-pressure profiles.
// ----------------------------------------------------------------------------
module greedy_box_suppression_top_tb;

    localparam int KEPT_SLOTS = int'(gbs_pkg::DEF_MAX_KEPT);

    typedef struct {
        bit       keep;
        bit [5:0] slot;
        bit       full;
    } t_verdict;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [gbs_pkg::IN_TDATA_W-1:0] s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tready  = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [gbs_pkg::THR_W-1:0]      cfg_data  = '0;

    wire                            s_tready;
    wire                            m_tvalid;
    wire [gbs_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire                            cfg_ready;

    greedy_box_suppression_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    gbs_pkg::t_box             kept_box  [KEPT_SLOTS];
    longint                    kept_area [KEPT_SLOTS];
    int                        kept_total = 0;
    bit [gbs_pkg::THR_W-1:0]   iou_thr    = gbs_pkg::THR_RESET;

    t_verdict         pending_verdicts[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 60;
    int fail_count    = 0;
    int boxes_sent    = 0;
    int beats_checked = 0;
    int kept_seen     = 0;
    int suppressed_seen = 0;
    int full_seen     = 0;
    int thr_writes    = 0;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic gbs_pkg::t_box make_box(int x, int y, int w, int h);
        gbs_pkg::t_box b;
        if (x < -32768) x = -32768;
        if (x > 32767)  x = 32767;
        if (y < -32768) y = -32768;
        if (y > 32767)  y = 32767;
        if (w < 0)      w = 0;
        if (w > 32767)  w = 32767;
        if (h < 0)      h = 0;
        if (h > 32767)  h = 32767;
        b.x = 16'(x);
        b.y = 16'(y);
        b.w = 15'(w);
        b.h = 15'(h);
        return b;
    endfunction

    // Greedy NMS step: suppress on inter*65536 > thr*union against any kept box.
    function automatic t_verdict nms_predict(bit first_box, gbs_pkg::t_box b);
        t_verdict v;
        longint   area, inter, uni;
        int       bx, by, bw, bh, kx, ky, kw, kh;
        int       left, top, right, bottom;
        bit       survive;
        if (first_box)
            kept_total = 0;
        bx = b.x;
        by = b.y;
        bw = b.w;
        bh = b.h;
        area = longint'(bw) * longint'(bh);
        survive = 1'b1;
        for (int i = 0; i < kept_total; i++) begin
            kx = kept_box[i].x;
            ky = kept_box[i].y;
            kw = kept_box[i].w;
            kh = kept_box[i].h;
            left   = (bx > kx) ? bx : kx;
            top    = (by > ky) ? by : ky;
            right  = (bx + bw < kx + kw) ? bx + bw : kx + kw;
            bottom = (by + bh < ky + kh) ? by + bh : ky + kh;
            if (right <= left || bottom <= top)
                inter = 0;
            else
                inter = longint'(right - left) * longint'(bottom - top);
            uni = area + kept_area[i] - inter;
            if (uni != 0 && inter * 65536 > longint'(iou_thr) * uni)
                survive = 1'b0;
        end
        v.keep = 1'b0;
        v.slot = '0;
        v.full = 1'b0;
        if (survive) begin
            v.keep = 1'b1;
            if (kept_total < KEPT_SLOTS) begin
                kept_box[kept_total]  = b;
                kept_area[kept_total] = area;
                v.slot = 6'(kept_total);
                kept_total++;
            end else begin
                v.full = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic send_box(bit first_box, gbs_pkg::t_box b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first_box;
        s_tdata  <= {2'b00, b.h, b.w, b.y, b.x};
        do @(posedge clk); while (!s_tready);
        pending_verdicts.insert(pending_verdicts.size(), nms_predict(first_box, b));
        boxes_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0 && guard < 50000) begin
            @(posedge clk);
            guard++;
        end
        if (pending_verdicts.size() != 0)
            note_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    endtask

    task automatic write_threshold(bit [gbs_pkg::THR_W-1:0] value);
        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        iou_thr = value;
        thr_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk) begin
        t_verdict want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_failure($sformatf("unexpected verdict beat tdata=%02h", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                beats_checked++;
                if (want.full)
                    full_seen++;
                else if (want.keep)
                    kept_seen++;
                else
                    suppressed_seen++;
                if (m_tdata[0] !== want.keep || m_tdata[6:1] !== want.slot
                        || m_tdata[7] !== want.full)
                    note_failure($sformatf(
                        "beat %0d: exp keep=%0b slot=%0d full=%0b, got keep=%b slot=%0d full=%b",
                        beats_checked, want.keep, want.slot, want.full,
                        m_tdata[0], m_tdata[6:1], m_tdata[7]));
            end
        end
    end

    // runs on the reset threshold, so it must come before any config write
    task automatic test_default_threshold();
        send_box(1'b1, make_box(0, 0, 160, 160));
        send_box(1'b0, make_box(0, 0, 160, 160));
        send_box(1'b0, make_box(40, 0, 160, 160));
        send_box(1'b0, make_box(80, 0, 160, 160));
        send_box(1'b0, make_box(160, 0, 160, 160));   // edge contact only with the first box
        send_box(1'b0, make_box(0, 160, 160, 160));
        send_box(1'b0, make_box(0, 0, 0, 50));        // zero width
        send_box(1'b0, make_box(0, 0, 0, 50));        // zero union against previous
        send_box(1'b0, make_box(5, 5, 0, 0));
        send_box(1'b1, make_box(-32768, -32768, 32767, 32767));
        send_box(1'b0, make_box(32767, 32767, 32767, 32767));
        send_box(1'b0, make_box(-1, -1, 32767, 32767));
        send_box(1'b0, make_box(-32768, -32768, 32767, 32767));
        send_box(1'b0, make_box(-32768, 32767, 32767, 0));
        send_box(1'b1, make_box(0, 0, 32767, 32767));
        send_box(1'b0, make_box(0, 0, 32767, 32766));
    endtask

    task automatic test_threshold_extremes();
        write_threshold(16'd0);
        send_box(1'b1, make_box(0, 0, 320, 320));
        send_box(1'b0, make_box(300, 300, 320, 320));  // any overlap suppresses
        send_box(1'b0, make_box(320, 0, 320, 320));
        send_box(1'b0, make_box(10, 10, 0, 0));
        send_box(1'b0, make_box(10, 10, 0, 0));
        write_threshold(16'hFFFF);
        send_box(1'b1, make_box(0, 0, 320, 320));
        send_box(1'b0, make_box(0, 0, 320, 320));
        send_box(1'b0, make_box(0, 0, 319, 320));
        write_threshold(16'd32768);
        send_box(1'b1, make_box(0, 0, 320, 320));
        send_box(1'b0, make_box(0, 0, 160, 320));      // IoU exactly one half
        send_box(1'b1, make_box(0, 0, 320, 320));
        send_box(1'b0, make_box(0, 0, 161, 320));
    endtask

    // 68 disjoint boxes on a 9-wide grid fill the store and overflow it
    task automatic test_store_full();
        gbs_pkg::t_box grid[68];
        int   col, row;
        write_threshold(16'($urandom_range(13107, 52428)));
        for (int i = 0; i < 68; i++) begin
            col = i % 9;
            row = i / 9;
            grid[i] = make_box(col * 512 - 2304 + int'($urandom_range(0, 64)),
                               row * 512 - 2048 + int'($urandom_range(0, 64)),
                               int'($urandom_range(1, 400)), int'($urandom_range(1, 400)));
            send_box(i == 0, grid[i]);
        end
        send_box(1'b0, grid[3]);
        send_box(1'b0, grid[66]);   // overflowed box was never stored
        send_box(1'b1, grid[66]);
    endtask

    task automatic run_random_phase(int n_items, int s_pct, int r_pct);
        int   sent, frames, frame_len, n_clusters, region, pick, roll, k, sw, sh;
        int   cx[30], cy[30], cw[30], ch[30];
        bit   fb;
        gbs_pkg::t_box b;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        frames = 0;
        while (sent < n_items) begin
            if (frames % 4 == 3) begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    write_threshold(16'd0);
                else if (roll == 1)
                    write_threshold(16'hFFFF);
                else if (roll == 2)
                    write_threshold(16'($urandom));
                else
                    write_threshold(16'($urandom_range(13107, 52428)));
            end
            frame_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 90))
                                                   : int'($urandom_range(1, 24));
            n_clusters = int'($urandom_range(1, (frame_len + 2) / 3));
            region = n_clusters * 512;
            for (k = 0; k < n_clusters; k++) begin
                cx[k] = int'($urandom_range(0, 2 * region)) - region;
                cy[k] = int'($urandom_range(0, 2 * region)) - region;
                cw[k] = int'($urandom_range(16, 640));
                ch[k] = int'($urandom_range(16, 640));
            end
            for (k = 0; k < frame_len; k++) begin
                roll = $urandom_range(0, 99);
                fb = (k == 0);
                if (roll < 75) begin
                    // jittered duplicate of a cluster box
                    pick = $urandom_range(0, n_clusters - 1);
                    sw = cw[pick] / 4;
                    sh = ch[pick] / 4;
                    b = make_box(cx[pick] + int'($urandom_range(0, sw)) - sw / 2,
                                 cy[pick] + int'($urandom_range(0, sh)) - sh / 2,
                                 cw[pick] + int'($urandom_range(0, sw)) - sw / 2,
                                 ch[pick] + int'($urandom_range(0, sh)) - sh / 2);
                end else if (roll < 90) begin
                    b = make_box(int'($urandom_range(0, 2 * region)) - region,
                                 int'($urandom_range(0, 2 * region)) - region,
                                 int'($urandom_range(0, 640)), int'($urandom_range(0, 640)));
                end else begin
                    b.x = 16'($urandom);
                    b.y = 16'($urandom);
                    b.w = 15'($urandom);
                    b.h = 15'($urandom);
                    fb  = 1'($urandom_range(0, 1));
                end
                send_box(fb, b);
                sent++;
            end
            frames++;
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_default_threshold();
        test_threshold_extremes();
        test_store_full();
        run_random_phase(180, 21, 60);
        run_random_phase(180, 60, 21);
        run_random_phase(180, 0, 0);
        wait_drained();
        repeat (80) @(posedge clk);
        $display("Sent %0d boxes, checked %0d verdicts: %0d kept, %0d suppressed, %0d store full",
                 boxes_sent, beats_checked, kept_seen, suppressed_seen, full_seen);
        $display("%0d threshold writes incl. 0 and 65535, three back-pressure profiles",
                 thr_writes);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
